FILE: src/crr_pkg.sv
// shared types and constants of the circle ring rasteriser
`default_nettype none
package crr_pkg;

  // coordinate width carried between front and back, covers any screen size allowed
  localparam int unsigned POS_W    = 14;
  localparam int unsigned CTR_W    = 14;
  localparam int unsigned RAD_W    = 12;
  localparam int unsigned RING_W   = 25;
  localparam int unsigned COLOR_W  = 16;
  localparam int unsigned DIMREG_W = 13;
  localparam int unsigned BPP_W    = 6;
  localparam int unsigned OFS_W    = 26;
  localparam int unsigned PIX_W    = 28;
  localparam int unsigned SQ_W     = 30;
  localparam int unsigned WIDE_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_STEP  = 1'b1
  } crr_func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_PIXEL_BITS    = 2'd2
  } crr_reg_e;

  // one classified item handed from front to back
  typedef struct packed {
    logic                     chk;
    logic                     done;
    logic [POS_W-1:0]         col;
    logic [POS_W-1:0]         row;
    logic signed [CTR_W-1:0]  cx;
    logic signed [CTR_W-1:0]  cy;
    logic [RING_W-1:0]        inner;
    logic [RING_W-1:0]        outer;
    logic [COLOR_W-1:0]       color;
  } crr_cmd_t;

endpackage
`default_nettype wire

FILE: src/crr_front.sv
// front: takes start and step beats, clips the box and walks the scan
`default_nettype none
module crr_front import crr_pkg::*; #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  accept_i,
  input  wire logic                  func_i,
  input  wire logic [CTR_W-1:0]      center_x_i,
  input  wire logic [CTR_W-1:0]      center_y_i,
  input  wire logic [RAD_W-1:0]      radius_i,
  input  wire logic [7:0]            red_i,
  input  wire logic [7:0]            green_i,
  input  wire logic [7:0]            blue_i,
  input  wire logic [DIMREG_W-1:0]   screen_width_i,
  input  wire logic [DIMREG_W-1:0]   screen_height_i,
  output crr_cmd_t                   cmd_o
);

  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam logic signed [WIDE_W-1:0] MaxDimS = WIDE_W'(MAX_DIM);

  logic                      busy_q, busy_d;
  logic [DIM_W-1:0]          scan_row_q, scan_row_d;
  logic [DIM_W-1:0]          scan_col_q, scan_col_d;
  logic [DIM_W-1:0]          col_first_q, col_first_d;
  logic [DIM_W-1:0]          col_limit_q, col_limit_d;
  logic [DIM_W-1:0]          row_limit_q, row_limit_d;
  logic signed [CTR_W-1:0]   cx_q, cx_d;
  logic signed [CTR_W-1:0]   cy_q, cy_d;
  logic [RING_W-1:0]         inner_q, inner_d;
  logic [RING_W-1:0]         outer_q, outer_d;
  logic [COLOR_W-1:0]        color_q, color_d;

  logic signed [WIDE_W-1:0]  cx_w, cy_w, rad_w;
  logic signed [WIDE_W-1:0]  c0_raw, c1_raw, r0_raw, r1_raw;
  logic signed [WIDE_W-1:0]  c0, c1, r0, r1, lim_w, lim_h;
  logic                      box_empty;
  logic [2*RAD_W-1:0]        rad_sq;
  logic [DIM_W-1:0]          col_inc, row_inc;
  logic                      col_wrap, row_end;

  // box bounds, signed, clipped at zero and at the screen size capped at MAX_DIM
  always_comb begin
    cx_w   = WIDE_W'(signed'(center_x_i));
    cy_w   = WIDE_W'(signed'(center_y_i));
    rad_w  = signed'(WIDE_W'(radius_i));
    c0_raw = cx_w - rad_w;
    c1_raw = cx_w + rad_w + WIDE_W'(1);
    r0_raw = cy_w - rad_w;
    r1_raw = cy_w + rad_w + WIDE_W'(1);
    lim_w  = (signed'(WIDE_W'(screen_width_i)) < MaxDimS) ?
             signed'(WIDE_W'(screen_width_i)) : MaxDimS;
    lim_h  = (signed'(WIDE_W'(screen_height_i)) < MaxDimS) ?
             signed'(WIDE_W'(screen_height_i)) : MaxDimS;
    c0     = (c0_raw > 0) ? c0_raw : '0;
    r0     = (r0_raw > 0) ? r0_raw : '0;
    c1     = (c1_raw < lim_w) ? c1_raw : lim_w;
    r1     = (r1_raw < lim_h) ? r1_raw : lim_h;
    box_empty = (c0 >= c1) || (r0 >= r1);
    rad_sq = radius_i * radius_i;
  end

  always_comb begin
    col_inc  = scan_col_q + DIM_W'(1);
    row_inc  = scan_row_q + DIM_W'(1);
    col_wrap = col_inc >= col_limit_q;
    row_end  = row_inc >= row_limit_q;
  end

  // next scan state
  always_comb begin
    busy_d      = busy_q;
    scan_row_d  = scan_row_q;
    scan_col_d  = scan_col_q;
    col_first_d = col_first_q;
    col_limit_d = col_limit_q;
    row_limit_d = row_limit_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    inner_d     = inner_q;
    outer_d     = outer_q;
    color_d     = color_q;
    if (accept_i) begin
      case (crr_func_e'(func_i))
        FUNC_START: begin
          cx_d    = signed'(center_x_i);
          cy_d    = signed'(center_y_i);
          outer_d = RING_W'(rad_sq) + RING_W'(radius_i);
          inner_d = RING_W'(rad_sq) - RING_W'(radius_i);
          color_d = {red_i[7:3], green_i[7:2], blue_i[7:3]};
          if (box_empty) begin
            busy_d      = 1'b0;
            col_first_d = '0;
            col_limit_d = '0;
            row_limit_d = '0;
            scan_row_d  = '0;
            scan_col_d  = '0;
          end else begin
            busy_d      = 1'b1;
            col_first_d = c0[DIM_W-1:0];
            col_limit_d = c1[DIM_W-1:0];
            row_limit_d = r1[DIM_W-1:0];
            scan_row_d  = r0[DIM_W-1:0];
            scan_col_d  = c0[DIM_W-1:0];
          end
        end
        FUNC_STEP: begin
          if (busy_q) begin
            if (col_wrap) begin
              scan_col_d = col_first_q;
              scan_row_d = row_inc;
              if (row_end) begin
                busy_d = 1'b0;
              end
            end else begin
              scan_col_d = col_inc;
            end
          end
        end
        default: begin
          busy_d = busy_q;
        end
      endcase
    end
  end

  // classified beat for the back
  always_comb begin
    cmd_o = '0;
    case (crr_func_e'(func_i))
      FUNC_START: begin
        cmd_o.done = box_empty;
      end
      FUNC_STEP: begin
        if (busy_q) begin
          cmd_o.chk   = 1'b1;
          cmd_o.done  = col_wrap && row_end;
          cmd_o.col   = POS_W'(scan_col_q);
          cmd_o.row   = POS_W'(scan_row_q);
          cmd_o.cx    = cx_q;
          cmd_o.cy    = cy_q;
          cmd_o.inner = inner_q;
          cmd_o.outer = outer_q;
          cmd_o.color = color_q;
        end else begin
          cmd_o.done = 1'b1;
        end
      end
      default: begin
        cmd_o.done = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      scan_row_q  <= '0;
      scan_col_q  <= '0;
      col_first_q <= '0;
      col_limit_q <= '0;
      row_limit_q <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      inner_q     <= '0;
      outer_q     <= '0;
      color_q     <= '0;
    end else begin
      busy_q      <= busy_d;
      scan_row_q  <= scan_row_d;
      scan_col_q  <= scan_col_d;
      col_first_q <= col_first_d;
      col_limit_q <= col_limit_d;
      row_limit_q <= row_limit_d;
      cx_q        <= cx_d;
      cy_q        <= cy_d;
      inner_q     <= inner_d;
      outer_q     <= outer_d;
      color_q     <= color_d;
    end
  end

endmodule
`default_nettype wire

FILE: src/crr_queue.sv
// short queue of classified beats between front and back
`default_nettype none
module crr_queue import crr_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  crr_cmd_t   data_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output crr_cmd_t   data_o,
  output logic       valid_o
);

  crr_cmd_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_q, rd_q;
  logic [QPTR_W:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = count_q == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (QPTR_W + 1)'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("queue pushed while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o))
    else $error("queue popped while empty");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !full_o && !pop_i) |=> count_q == $past(count_q) + (QPTR_W + 1)'(1))
    else $error("queue fill count lost a beat");
`endif

endmodule
`default_nettype wire

FILE: src/crr_back.sv
// back: distance test and byte offset, three register stages to the output
`default_nettype none
module crr_back import crr_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cmd_valid_i,
  input  crr_cmd_t                  cmd_i,
  output logic                      cmd_pop_o,
  input  wire logic [DIMREG_W-1:0]  screen_width_i,
  input  wire logic [BPP_W-1:0]     pixel_bits_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      write_enable_o,
  output logic [OFS_W-1:0]          byte_offset_o,
  output logic [COLOR_W-1:0]        pixel_color_o,
  output logic                      done_o
);

  // stage 1: centre deltas and pixel index
  logic                       v1_q;
  logic                       chk1_q, done1_q;
  logic signed [WIDE_W-1:0]   dx1_q, dy1_q;
  logic [PIX_W-1:0]           pix1_q;
  logic [RING_W-1:0]          inner1_q, outer1_q;
  logic [COLOR_W-1:0]         color1_q;
  // stage 2: squares and scaled index
  logic                       v2_q;
  logic                       chk2_q, done2_q;
  logic [SQ_W-1:0]            sqx2_q, sqy2_q;
  logic [PIX_W+BPP_W-1:0]     prod2_q;
  logic [RING_W-1:0]          inner2_q, outer2_q;
  logic [COLOR_W-1:0]         color2_q;
  // stage 3: output register
  logic                       v3_q;
  logic                       we3_q, done3_q;
  logic [OFS_W-1:0]           ofs3_q;
  logic [COLOR_W-1:0]         color3_q;

  logic                       en1, en2, en3;
  logic signed [WIDE_W-1:0]   dx_d, dy_d;
  logic [PIX_W-1:0]           pix_d;
  logic signed [2*WIDE_W-1:0] sqx_full, sqy_full;
  logic [SQ_W-1:0]            dist_sq;
  logic                       on_ring;

  assign en3       = !v3_q || out_ready_i;
  assign en2       = !v2_q || en3;
  assign en1       = !v1_q || en2;
  assign cmd_pop_o = cmd_valid_i && en1;

  always_comb begin
    dx_d  = signed'(WIDE_W'(cmd_i.col)) - WIDE_W'(cmd_i.cx);
    dy_d  = signed'(WIDE_W'(cmd_i.row)) - WIDE_W'(cmd_i.cy);
    pix_d = PIX_W'(cmd_i.row) * PIX_W'(screen_width_i) + PIX_W'(cmd_i.col);
  end

  always_comb begin
    sqx_full = dx1_q * dx1_q;
    sqy_full = dy1_q * dy1_q;
  end

  always_comb begin
    dist_sq = sqx2_q + sqy2_q;
    on_ring = chk2_q && (dist_sq >= SQ_W'(inner2_q)) && (dist_sq <= SQ_W'(outer2_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= cmd_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && cmd_valid_i) begin
      chk1_q   <= cmd_i.chk;
      done1_q  <= cmd_i.done;
      dx1_q    <= dx_d;
      dy1_q    <= dy_d;
      pix1_q   <= pix_d;
      inner1_q <= cmd_i.inner;
      outer1_q <= cmd_i.outer;
      color1_q <= cmd_i.color;
    end
    if (en2 && v1_q) begin
      chk2_q   <= chk1_q;
      done2_q  <= done1_q;
      sqx2_q   <= SQ_W'(sqx_full);
      sqy2_q   <= SQ_W'(sqy_full);
      prod2_q  <= pix1_q * pixel_bits_i;
      inner2_q <= inner1_q;
      outer2_q <= outer1_q;
      color2_q <= color1_q;
    end
    if (en3 && v2_q) begin
      we3_q    <= on_ring;
      done3_q  <= done2_q;
      // divide by eight and keep 26 bits
      ofs3_q   <= on_ring ? prod2_q[OFS_W+2:3] : '0;
      color3_q <= on_ring ? color2_q : '0;
    end
  end

  assign out_valid_o    = v3_q;
  assign write_enable_o = we3_q;
  assign byte_offset_o  = ofs3_q;
  assign pixel_color_o  = color3_q;
  assign done_o         = done3_q;

`ifndef SYNTHESIS
  a_off_ring_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !we3_q) |-> (ofs3_q == '0 && color3_q == '0))
    else $error("pixel off the ring carries an offset or colour");
  a_stage2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !en2) |=> v2_q)
    else $error("stalled stage two dropped its beat");
  a_stage1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !en1) |=> (v1_q && $stable(pix1_q) && $stable(dx1_q)))
    else $error("stalled stage one changed");
`endif

endmodule
`default_nettype wire

FILE: src/circle_ring_rasterizer_unit.sv
// top level of the circle ring rasteriser
`default_nettype none
// Takes one beat per clock while the queue has room: a start beat (tuser 0) latches
// centre, radius and colour and clips the bounding box; each step beat (tuser 1)
// tests the next pixel of the box, row by row, and gives one result beat with write
// enable, byte offset and RGB565 colour; tlast marks the last pixel, an empty box or
// a step while idle. Throughput is one beat per cycle in both directions while the
// queue is not full and the output is not stalled; a beat is registered in the
// queue, then in the delta, square and compare stages of the back end.
// A four-entry queue lets the front keep taking beats while the output stalls.
// The screen registers may only be written while no beat is in flight.
module circle_ring_rasterizer_unit import crr_pkg::*; #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // center_x[13:0], center_y[27:14], radius[39:28], red[47:40], green[55:48],
  // blue[63:56]
  input  wire logic [63:0]           s_axis_tdata,
  // func[0]
  input  wire logic                  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // byte_offset[25:0], pixel_color[41:26], zero[47:42]
  output logic [47:0]                m_axis_tdata,
  // write_enable[0]
  output logic                       m_axis_tuser,
  // done_res
  output logic                       m_axis_tlast,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [DIMREG_W-1:0]   cfg_wdata_i
);

  logic [DIMREG_W-1:0]  screen_width_q;
  logic [DIMREG_W-1:0]  screen_height_q;
  logic [BPP_W-1:0]     pixel_bits_q;

  logic                 in_accept;
  logic                 q_full, q_valid, q_pop;
  crr_cmd_t             front_cmd, q_cmd;
  logic [OFS_W-1:0]     byte_offset;
  logic [COLOR_W-1:0]   pixel_color;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= DIMREG_W'(640);
      screen_height_q <= DIMREG_W'(480);
      pixel_bits_q    <= BPP_W'(16);
    end else if (cfg_we_i) begin
      case (crr_reg_e'(cfg_idx_i))
        REG_SCREEN_WIDTH:  screen_width_q  <= cfg_wdata_i;
        REG_SCREEN_HEIGHT: screen_height_q <= cfg_wdata_i;
        REG_PIXEL_BITS:    pixel_bits_q    <= cfg_wdata_i[BPP_W-1:0];
        default: begin
          screen_width_q <= screen_width_q;
        end
      endcase
    end
  end

  assign s_axis_tready = !q_full;
  assign in_accept     = s_axis_tvalid && !q_full;

  crr_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (in_accept),
    .func_i          (s_axis_tuser),
    .center_x_i      (s_axis_tdata[13:0]),
    .center_y_i      (s_axis_tdata[27:14]),
    .radius_i        (s_axis_tdata[39:28]),
    .red_i           (s_axis_tdata[47:40]),
    .green_i         (s_axis_tdata[55:48]),
    .blue_i          (s_axis_tdata[63:56]),
    .screen_width_i  (screen_width_q),
    .screen_height_i (screen_height_q),
    .cmd_o           (front_cmd)
  );

  crr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_accept),
    .data_i  (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_cmd),
    .valid_o (q_valid)
  );

  crr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (q_valid),
    .cmd_i          (q_cmd),
    .cmd_pop_o      (q_pop),
    .screen_width_i (screen_width_q),
    .pixel_bits_i   (pixel_bits_q),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .write_enable_o (m_axis_tuser),
    .byte_offset_o  (byte_offset),
    .pixel_color_o  (pixel_color),
    .done_o         (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, pixel_color, byte_offset};

endmodule
`default_nettype wire
